[rtl/tcgr_pkg.sv]
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types and constants shared by the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // glyph width in pixels, one font byte per glyph row
  localparam int GLYPH_COLS = 8;
  localparam int GLYPH_BITS = 8;

  localparam logic [12:0] CURSOR_MAX = 13'd8191;
  localparam logic [4:0]  LINE_STEP  = 5'd16;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // item kinds carried in tuser
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CURSOR = 2'd1;
  localparam logic [1:0] FUNC_PRINT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_WIDTH      = 2'd1;
  localparam logic [1:0] REG_HEIGHT     = 2'd2;
  localparam logic [1:0] REG_PITCH      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_CHECK,
    ST_MUL,
    ST_BASE,
    ST_EMIT
  } state_t;

  function automatic logic [12:0] sat_add13(input logic [12:0] v, input logic [4:0] d);
    logic [13:0] s;
    s = {1'b0, v} + {9'd0, d};
    return (s > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : s[12:0];
  endfunction

endpackage

[rtl/tcgr_glyph_store.sv]
// ----------------------------------------------------------------------------
// tcgr_glyph_store
// Font memory: one byte per glyph row, one write and one registered read.
// ----------------------------------------------------------------------------
module tcgr_glyph_store
  import tcgr_pkg::*;
#(
  parameter int CODE_W = 8,
  parameter int ROW_W  = 4
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [CODE_W+ROW_W-1:0] wr_addr,
  input  logic [GLYPH_BITS-1:0]   wr_data,
  input  logic [CODE_W+ROW_W-1:0] rd_addr,
  output logic [GLYPH_BITS-1:0]   rd_data
);

  localparam int DEPTH = 1 << (CODE_W + ROW_W);

  logic [GLYPH_BITS-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/text_console_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Renders 8-pixel-wide bitmap glyphs into a 32-bit-per-pixel framebuffer as
// one masked row write per glyph row, and keeps the text cursor.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid / s_tready  func in tuser, item fields in tdata
//  m_*       out        m_tvalid / m_tready  row write in tdata, tlast on last row
//  cfg_*     in         cfg_wr_en            register index and write data
//
//  A font load, set cursor, newline or carriage return is done in the idle state as the item is taken.
//  A printed character steps through wrap, bottom check, one multiply of line
//  by pitch, the base add, then one row a cycle, unless m_tready stalls, out
//  of the glyph store read port through the shared address adder.
//  Reset is synchronous; the glyph store is not cleared.
//  A stall on m_tready holds the row sequencer; s_tready is low while busy.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_ROWS = 16,
  parameter int CHAR_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code[7:0], font_row[11:8], font_bits[19:12], pos_x[32:20],
  // pos_y[45:33], color[77:46], zero pad[79:78]
  input  logic [79:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_addr[31:0], pixel_mask[39:32], pixel_value[71:40]
  output logic [71:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ROW_W  = $clog2(GLYPH_ROWS);
  localparam int CODE_W = $clog2(CHAR_COUNT);

  // input fields
  logic [7:0]  in_code;
  logic [3:0]  in_frow;
  logic [7:0]  in_bits;
  logic [12:0] in_x;
  logic [12:0] in_y;
  logic [31:0] in_color;
  logic        in_take;

  assign in_code  = s_tdata[7:0];
  assign in_frow  = s_tdata[11:8];
  assign in_bits  = s_tdata[19:12];
  assign in_x     = s_tdata[32:20];
  assign in_y     = s_tdata[45:33];
  assign in_color = s_tdata[77:46];
  assign in_take  = s_tvalid && s_tready;

  // configuration
  logic [31:0] frame_base;
  logic [13:0] screen_width;
  logic [13:0] screen_height;
  logic [14:0] row_pitch;

  // control state
  state_t      state, state_next;
  logic [12:0] cursor_x, cursor_x_next;
  logic [12:0] cursor_y, cursor_y_next;
  logic [ROW_W-1:0] row, row_next;
  logic        out_valid, out_valid_next;

  // payload
  logic [7:0]  code;
  logic        code_ok;
  logic [31:0] color;
  logic [27:0] line_prod;
  logic [31:0] addr_acc;
  logic [31:0] out_addr;
  logic [7:0]  out_mask;
  logic [31:0] out_value;
  logic        out_last;

  logic        load_row;
  logic        row_last;
  logic [ROW_W-1:0] row_sel;
  logic [7:0]  glyph_q;

  // glyph store ports
  logic                    st_wr_en;
  logic [CODE_W+ROW_W-1:0] st_wr_addr;
  logic [CODE_W+ROW_W-1:0] st_rd_addr;
  logic [5:0]              frow_ext;

  assign frow_ext   = {2'b00, in_frow};
  assign st_wr_en   = in_take && (s_tuser == FUNC_LOAD)
                      && ({1'b0, in_code} < 9'(CHAR_COUNT))
                      && (frow_ext < 6'(GLYPH_ROWS));
  assign st_wr_addr = {in_code[CODE_W-1:0], frow_ext[ROW_W-1:0]};
  assign st_rd_addr = {code[CODE_W-1:0], row_sel};

  tcgr_glyph_store #(
    .CODE_W (CODE_W),
    .ROW_W  (ROW_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (in_bits),
    .rd_addr (st_rd_addr),
    .rd_data (glyph_q)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_value, out_mask, out_addr};
  assign m_tlast  = out_last;

  assign load_row = (state == ST_EMIT) && (!out_valid || m_tready);
  assign row_last = (row == ROW_W'(GLYPH_ROWS - 1));
  // read ahead so the store output always matches the current row
  assign row_sel  = load_row ? ROW_W'(row + ROW_W'(1)) : row;

  always_comb begin
    state_next     = state;
    cursor_x_next  = cursor_x;
    cursor_y_next  = cursor_y;
    row_next       = row;
    out_valid_next = out_valid;

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (s_tuser == FUNC_CURSOR) begin
            cursor_x_next = in_x;
            cursor_y_next = in_y;
          end else if (s_tuser == FUNC_PRINT) begin
            if (in_code == CHAR_NL) begin
              cursor_x_next = '0;
              cursor_y_next = sat_add13(cursor_y, LINE_STEP);
            end else if (in_code == CHAR_CR) begin
              cursor_x_next = '0;
            end else begin
              state_next = ST_WRAP;
            end
          end
        end
      end
      ST_WRAP: begin
        if ({1'b0, cursor_x} + 14'(GLYPH_COLS) > screen_width) begin
          cursor_x_next = '0;
          cursor_y_next = sat_add13(cursor_y, LINE_STEP);
        end
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // drop the character if it would cross the bottom edge
        row_next = '0;
        if ({1'b0, cursor_y} + 14'(GLYPH_ROWS) > screen_height) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_BASE;
      end
      ST_BASE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_row) begin
          out_valid_next = 1'b1;
          row_next       = ROW_W'(row + ROW_W'(1));
          if (row_last) begin
            cursor_x_next = sat_add13(cursor_x, 5'(GLYPH_COLS));
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cursor_x      <= '0;
      cursor_y      <= '0;
      row           <= '0;
      out_valid     <= 1'b0;
      frame_base    <= '0;
      screen_width  <= '0;
      screen_height <= '0;
      row_pitch     <= '0;
    end else begin
      state     <= state_next;
      cursor_x  <= cursor_x_next;
      cursor_y  <= cursor_y_next;
      row       <= row_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_BASE: frame_base    <= cfg_data;
          REG_WIDTH:      screen_width  <= cfg_data[13:0];
          REG_HEIGHT:     screen_height <= cfg_data[13:0];
          REG_PITCH:      row_pitch     <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // datapath: one multiplier, then one shared adder stepping the row address
  always_ff @(posedge clk) begin
    if (in_take) begin
      code    <= in_code;
      code_ok <= ({1'b0, in_code} < 9'(CHAR_COUNT));
      color   <= in_color;
    end
    if (state == ST_MUL) begin
      line_prod <= cursor_y * row_pitch;
    end
    if (state == ST_BASE) begin
      addr_acc <= frame_base + {17'd0, cursor_x, 2'b00} + {2'b00, line_prod, 2'b00};
    end
    if (load_row) begin
      out_addr  <= addr_acc;
      out_mask  <= code_ok ? glyph_q : 8'd0;
      out_value <= color;
      out_last  <= row_last;
      addr_acc  <= addr_acc + {15'd0, row_pitch, 2'b00};
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the text console glyph renderer end to end. Font rows, cursor moves
// and printed characters go in on the slave stream; a scoreboard keeps its
// own font, cursor and register copies, works out the row writes of every
// accepted item and compares each row write coming out, field by field.
// Runs directed corner cases first, then random traffic under several screen
// settings and three patterns of back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import tcgr_pkg::*;

  localparam int GLYPH_ROWS = 16;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum {GLYPH_RANDOM, GLYPH_SOLID, GLYPH_BLANK} glyph_fill_e;

  // first field of the stream item in the lowest bits
  typedef struct packed {
    logic [31:0] color;
    logic [12:0] pos_y;
    logic [12:0] pos_x;
    logic [7:0]  font_bits;
    logic [3:0]  font_row;
    logic [7:0]  char_code;
  } console_item_t;

  typedef struct {
    logic [31:0] addr;
    logic [7:0]  mask;
    logic [31:0] value;
    logic        last;
  } row_write_t;

  class glyph_write_scoreboard;
    logic [7:0]  glyph_rom [4096];
    int unsigned frame_base, scr_width, scr_height, pitch;
    int unsigned cur_x, cur_y;
    row_write_t  pending_rows [$];
    int          errors;

    function new();
      frame_base = 0;
      scr_width  = 0;
      scr_height = 0;
      pitch      = 0;
      cur_x      = 0;
      cur_y      = 0;
      errors     = 0;
    endfunction

    function int unsigned bump(int unsigned v, int unsigned d);
      return (v + d > CURSOR_MAX) ? CURSOR_MAX : v + d;
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_FRAME_BASE: frame_base = val;
        REG_WIDTH:      scr_width  = val[13:0];
        REG_HEIGHT:     scr_height = val[13:0];
        REG_PITCH:      pitch      = val[14:0];
        default: ;
      endcase
    endfunction

    // work out the row writes caused by one accepted item
    function void take_item(logic [1:0] func, console_item_t it);
      row_write_t rw;
      longint unsigned a;
      case (func)
        FUNC_LOAD:   glyph_rom[{it.char_code, it.font_row}] = it.font_bits;
        FUNC_CURSOR: begin
          cur_x = it.pos_x;
          cur_y = it.pos_y;
        end
        FUNC_PRINT: begin
          if (it.char_code == CHAR_NL) begin
            cur_x = 0;
            cur_y = bump(cur_y, LINE_STEP);
            return;
          end
          if (it.char_code == CHAR_CR) begin
            cur_x = 0;
            return;
          end
          // wrap first, the bottom check still applies afterwards
          if (cur_x + GLYPH_COLS > scr_width) begin
            cur_x = 0;
            cur_y = bump(cur_y, LINE_STEP);
          end
          if (cur_y + GLYPH_ROWS > scr_height) return;
          for (int i = 0; i < GLYPH_ROWS; i++) begin
            a = frame_base;
            a = a + 64'(4) * cur_x + 64'(4) * (cur_y + i) * pitch;
            rw.addr  = a[31:0];
            rw.mask  = glyph_rom[{it.char_code, 4'(i)}];
            rw.value = it.color;
            rw.last  = (i == GLYPH_ROWS - 1);
            pending_rows.push_back(rw);
          end
          cur_x = bump(cur_x, GLYPH_COLS);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_row(logic [71:0] data, logic tlast);
      row_write_t want;
      if (pending_rows.size() == 0) begin
        report($sformatf("row write with nothing pending, addr %h", data[31:0]));
        return;
      end
      want = pending_rows.pop_front();
      if (data[31:0] !== want.addr)
        report($sformatf("addr %h, want %h", data[31:0], want.addr));
      if (data[39:32] !== want.mask)
        report($sformatf("mask %h, want %h (addr %h)", data[39:32], want.mask, want.addr));
      if (data[71:40] !== want.value)
        report($sformatf("value %h, want %h (addr %h)", data[71:40], want.value, want.addr));
      if (tlast !== want.last)
        report($sformatf("tlast %b, want %b (addr %h)", tlast, want.last, want.addr));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // char_code, font_row, font_bits, pos_x, pos_y, color, zero pad
  logic [79:0] s_tdata = '0;
  // func
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // pixel_addr, pixel_mask, pixel_value
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  glyph_write_scoreboard console_sb;
  int          send_idle = 15;
  int          recv_idle = 86;
  int unsigned scr_w, scr_h;
  logic [7:0]  font_codes [$];

  text_console_glyph_renderer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sample the row write stream and draw the next ready level
  always @(posedge clk) begin
    if (m_tvalid && m_tready) console_sb.check_row(m_tdata, m_tlast);
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic console_item_t rand_item();
    console_item_t it;
    it.char_code = 8'($urandom_range(0, 255));
    it.font_row  = 4'($urandom_range(0, 15));
    it.font_bits = 8'($urandom_range(0, 255));
    it.pos_x     = 13'($urandom_range(0, 8191));
    it.pos_y     = 13'($urandom_range(0, 8191));
    it.color     = $urandom;
    return it;
  endfunction

  task automatic send_item(input logic [1:0] func, input console_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, it};
    do @(posedge clk); while (!s_tready);
    console_sb.take_item(func, it);
  endtask

  task automatic load_glyph(input logic [7:0] code, input glyph_fill_e fill);
    console_item_t it;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      it = rand_item();
      it.char_code = code;
      it.font_row  = 4'(r);
      if (fill == GLYPH_SOLID) it.font_bits = 8'hFF;
      if (fill == GLYPH_BLANK) it.font_bits = 8'h00;
      send_item(FUNC_LOAD, it);
    end
    if (!(code inside {font_codes})) font_codes.push_back(code);
  endtask

  task automatic print_char(input logic [7:0] code);
    console_item_t it;
    it = rand_item();
    it.char_code = code;
    send_item(FUNC_PRINT, it);
  endtask

  task automatic set_cursor(input logic [12:0] x, input logic [12:0] y);
    console_item_t it;
    it = rand_item();
    it.pos_x = x;
    it.pos_y = y;
    send_item(FUNC_CURSOR, it);
  endtask

  // wait for every pending row, then let a dropped character finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (console_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] base, input logic [31:0] w,
                              input logic [31:0] h, input logic [31:0] p);
    logic [1:0]  idx  [4];
    logic [31:0] vals [4];
    idx  = '{REG_FRAME_BASE, REG_WIDTH, REG_HEIGHT, REG_PITCH};
    vals = '{base, w, h, p};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      console_sb.set_reg(idx[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    scr_w = w[13:0];
    scr_h = h[13:0];
  endtask

  task automatic random_traffic(input int target);
    int             sent;
    int             r;
    int             n;
    int unsigned    x, y;
    console_item_t  it;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // mostly inside the visible area so that prints land
        if ($urandom_range(0, 3) == 0) begin
          set_cursor(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        end else begin
          x = $urandom_range(0, (scr_w >= 8) ? scr_w - 8 : 0);
          y = $urandom_range(0, (scr_h >= 16) ? scr_h - 16 : 0);
          set_cursor(13'((x > 8191) ? 8191 : x), 13'((y > 8191) ? 8191 : y));
        end
        sent++;
      end else if (r < 14) begin
        load_glyph(8'($urandom_range(0, 255)), GLYPH_RANDOM);
        sent += GLYPH_ROWS;
      end else if (r < 22) begin
        send_item(FUNC_LOAD, rand_item());
        sent++;
      end else if (r < 26) begin
        print_char(($urandom_range(0, 1) == 0) ? CHAR_NL : CHAR_CR);
        sent++;
      end else if (r < 29) begin
        send_item(FUNC_UNUSED, rand_item());
        sent++;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) print_char(font_codes[$urandom_range(0, font_codes.size() - 1)]);
        sent += n;
      end
    end
  endtask

  initial begin
    console_sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // font for the directed part, under the reset settings
    load_glyph(8'hFF, GLYPH_SOLID);
    load_glyph(8'h00, GLYPH_BLANK);
    load_glyph(8'h41, GLYPH_RANDOM);
    load_glyph(8'h80, GLYPH_RANDOM);
    print_char(8'h41);
    drain();

    write_config(32'h0000_1000, 32, 32, 40);
    set_cursor(0, 0);
    print_char(8'hFF);
    print_char(8'h00);
    print_char(8'h41);
    print_char(8'h80);
    print_char(8'h41);
    print_char(CHAR_CR);
    print_char(8'hFF);
    print_char(CHAR_NL);
    print_char(8'h41);
    send_item(FUNC_UNUSED, rand_item());
    set_cursor(13'd8191, 13'd8191);
    print_char(8'h41);
    print_char(CHAR_NL);
    set_cursor(13'd8191, 0);
    print_char(8'h80);
    drain();

    // largest screen: address wraps and cursor saturation
    write_config(32'hFFFF_FFF0, 8192, 8192, 16384);
    set_cursor(13'd8184, 13'd8176);
    print_char(8'hFF);
    print_char(8'h41);
    set_cursor(0, 0);
    print_char(8'h80);
    drain();

    write_config($urandom, $urandom_range(8, 200), $urandom_range(16, 100),
                 $urandom_range(0, 16384));
    random_traffic(40);
    drain();

    send_idle = 86;
    recv_idle = 15;
    write_config($urandom, 8, 16, 8);
    random_traffic(40);
    drain();
    write_config(32'hFFFF_FFFF, 8192, 8192, 16384);
    random_traffic(40);
    drain();
    write_config($urandom, $urandom_range(8, 200), $urandom_range(16, 100),
                 $urandom_range(0, 16384));
    random_traffic(40);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_config($urandom, 0, 0, 0);
    random_traffic(20);
    drain();
    scr_w = $urandom_range(64, 640);
    write_config($urandom, scr_w, $urandom_range(32, 480), scr_w + $urandom_range(0, 64));
    random_traffic(60);
    drain();

    if (console_sb.errors == 0 && console_sb.pending() == 0) begin
      $display("[text_console_glyph_renderer] OK");
    end else begin
      $display("[text_console_glyph_renderer] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[text_console_glyph_renderer] ERROR");
    $finish;
  end

endmodule
